// ===== rtl/utf8_whitespace_position_tracker_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the whitespace position tracker
// Concurrent checks clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef UTF8_WHITESPACE_POSITION_TRACKER_UNIT_MACROS_SVH
`define UTF8_WHITESPACE_POSITION_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define UWPT_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uwpt assertion failed");
// Next-cycle implication
`define UWPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uwpt assertion failed");
`else
`define UWPT_ASSERT_IMPLY(label, ante, cons)
`define UWPT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/uwpt_pkg.sv =====
// ----------------------------------------------------------------------------
// uwpt_pkg
// Widths, codes, byte constants and command/status types of the tracker.
// ----------------------------------------------------------------------------
package uwpt_pkg;

   localparam int LINE_BITS    = 24;
   localparam int COL_BITS     = 16;
   localparam int LEN_BITS     = 16;
   localparam int TAB_BITS     = 7;
   localparam int DIV_CNT_BITS = $clog2(COL_BITS + 1);

   localparam logic [TAB_BITS-1:0] TAB_SIZE_RESET = TAB_BITS'(4);

   // Commands on the request channel
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_BYTE  = 1'b1;

   // Result status codes
   localparam logic [2:0] ST_STARTED  = 3'd0;
   localparam logic [2:0] ST_PENDING  = 3'd1;
   localparam logic [2:0] ST_CONSUMED = 3'd2;
   localparam logic [2:0] ST_STOPPED  = 3'd3;
   localparam logic [2:0] ST_IGNORED  = 3'd4;

   // Text bytes of interest
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] LEAD_C2  = 8'hc2;
   localparam logic [7:0] LEAD_E1  = 8'he1;
   localparam logic [7:0] LEAD_E2  = 8'he2;
   localparam logic [7:0] LEAD_E3  = 8'he3;
   localparam logic [7:0] CONT_80  = 8'h80;
   localparam logic [7:0] CONT_81  = 8'h81;
   localparam logic [7:0] CONT_85  = 8'h85;
   localparam logic [7:0] CONT_8A  = 8'h8a;
   localparam logic [7:0] CONT_9A  = 8'h9a;
   localparam logic [7:0] CONT_9F  = 8'h9f;
   localparam logic [7:0] CONT_A0  = 8'ha0;
   localparam logic [7:0] CONT_A8  = 8'ha8;
   localparam logic [7:0] CONT_A9  = 8'ha9;
   localparam logic [7:0] CONT_AF  = 8'haf;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // request transaction taken this cycle
      logic step;      // one remainder iteration
      logic finish;    // complete the tab update
      logic load_out;  // load the response register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic needs_div;  // current request is a tab that needs the remainder
   } dp_status_type;

endpackage

// ===== rtl/uwpt_req_if.sv =====
// ----------------------------------------------------------------------------
// uwpt_req_if
// Request channel: start command or one text byte, valid/ready handshake.
// ----------------------------------------------------------------------------
interface uwpt_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [7:0]                     data_byte;
   logic [uwpt_pkg::LINE_BITS-1:0] start_line;
   logic [uwpt_pkg::COL_BITS-1:0]  start_col;
   logic                           one_newline;

   modport source (output valid, cmd, data_byte, start_line, start_col, one_newline,
                   input ready);
   modport sink   (input valid, cmd, data_byte, start_line, start_col, one_newline,
                   output ready);
endinterface

// ===== rtl/uwpt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// uwpt_rsp_if
// Response channel: status and position per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface uwpt_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [2:0]                     status;
   logic [uwpt_pkg::LEN_BITS-1:0]  run_length;
   logic [uwpt_pkg::LINE_BITS-1:0] line;
   logic [uwpt_pkg::COL_BITS-1:0]  col;
   logic                           done_res;

   modport source (output valid, status, run_length, line, col, done_res,
                   input ready);
   modport sink   (input valid, status, run_length, line, col, done_res,
                   output ready);
endinterface

// ===== rtl/uwpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// uwpt_ctrl
// Controller: handshakes, tab remainder sequencing and response valid.
// ----------------------------------------------------------------------------
`include "utf8_whitespace_position_tracker_unit_macros.svh"

module uwpt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  uwpt_pkg::dp_status_type status,
   output uwpt_pkg::ctrl_cmd_type  cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DIV  = 1'b1;

   localparam logic [uwpt_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
      uwpt_pkg::DIV_CNT_BITS'(uwpt_pkg::COL_BITS);

   logic                              state_ff, state_in;
   logic [uwpt_pkg::DIV_CNT_BITS-1:0] count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              out_free;
   logic                              div_done;

   // Response register is free when empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign div_done  = (count_ff == CNT_LAST);
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;

   // Decode commands
   always_comb begin
      cmd.accept   = req_valid && req_ready;
      cmd.step     = (state_ff == S_DIV) && !div_done;
      cmd.finish   = (state_ff == S_DIV) && div_done && out_free;
      cmd.load_out = (cmd.accept && !status.needs_div) || cmd.finish;
   end

   // Advance state and iteration count
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.accept && status.needs_div) begin
               state_in = S_DIV;
               count_in = '0;
            end
         end
         S_DIV: begin
            if (cmd.step) begin
               count_in = count_ff + uwpt_pkg::DIV_CNT_BITS'(1);
            end
            if (cmd.finish) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `UWPT_ASSERT_NEXT(a_tab_enters_div, cmd.accept && status.needs_div, state_ff == S_DIV)
   `UWPT_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, rsp_valid_ff)
   `UWPT_ASSERT_NEXT(a_count_advances, cmd.step,
                     count_ff == $past(count_ff) + uwpt_pkg::DIV_CNT_BITS'(1))
   `UWPT_ASSERT_IMPLY(a_no_accept_in_div, state_ff == S_DIV, !cmd.accept && !cmd.load_out
                      || cmd.finish)

endmodule

// ===== rtl/uwpt_datapath.sv =====
// ----------------------------------------------------------------------------
// uwpt_datapath
// Position state, whitespace decode, tab remainder unit and response register.
// ----------------------------------------------------------------------------
module uwpt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  uwpt_pkg::ctrl_cmd_type         cmd,
   output uwpt_pkg::dp_status_type        status,
   input  logic                           csr_write_enable,
   input  logic [uwpt_pkg::TAB_BITS-1:0]  csr_write_data,
   input  logic                           req_cmd,
   input  logic [7:0]                     req_data_byte,
   input  logic [uwpt_pkg::LINE_BITS-1:0] req_start_line,
   input  logic [uwpt_pkg::COL_BITS-1:0]  req_start_col,
   input  logic                           req_one_newline,
   output logic [2:0]                     rsp_status,
   output logic [uwpt_pkg::LEN_BITS-1:0]  rsp_run_length,
   output logic [uwpt_pkg::LINE_BITS-1:0] rsp_line,
   output logic [uwpt_pkg::COL_BITS-1:0]  rsp_col,
   output logic                           rsp_done_res
);

   localparam int LB = uwpt_pkg::LINE_BITS;
   localparam int CB = uwpt_pkg::COL_BITS;
   localparam int NB = uwpt_pkg::LEN_BITS;
   localparam int TB = uwpt_pkg::TAB_BITS;

   function automatic logic [NB-1:0] sat_len(input logic [NB-1:0] v, input logic [1:0] d);
      logic [NB:0] s;
      s = {1'b0, v} + {{(NB-1){1'b0}}, d};
      return s[NB] ? {NB{1'b1}} : s[NB-1:0];
   endfunction

   function automatic logic [CB-1:0] sat_col(input logic [CB-1:0] v, input logic [TB-1:0] d);
      logic [CB:0] s;
      s = {1'b0, v} + {{(CB+1-TB){1'b0}}, d};
      return s[CB] ? {CB{1'b1}} : s[CB-1:0];
   endfunction

   function automatic logic [LB-1:0] sat_line(input logic [LB-1:0] v);
      logic [LB:0] s;
      s = {1'b0, v} + {{LB{1'b0}}, 1'b1};
      return s[LB] ? {LB{1'b1}} : s[LB-1:0];
   endfunction

   // Configuration and position state
   logic [TB-1:0] tab_size_ff;
   logic [LB-1:0] line_ff, line_in;
   logic [CB-1:0] col_ff, col_in;
   logic [NB-1:0] len_ff, len_in;
   logic [7:0]    pfx0_ff, pfx0_in;
   logic [7:0]    pfx1_ff, pfx1_in;
   logic [1:0]    pcnt_ff, pcnt_in;
   logic          after_cr_ff, after_cr_in;
   logic          stop_ff, stop_in;
   logic          active_ff, active_in;
   logic [2:0]    step_status;
   logic          needs_div;

   // Tab remainder unit
   logic [CB-1:0] dvd_ff;
   logic [TB-1:0] rem_ff;
   logic [TB-1:0] ts_ff;
   logic [TB:0]   trial;
   logic [TB-1:0] rem_next;
   logic [TB-1:0] tab_off;
   logic [TB-1:0] tab_inc;
   logic [CB-1:0] col_tab;
   logic [NB-1:0] len_tab;

   // Response register
   logic [2:0]    out_status_ff;
   logic [NB-1:0] out_len_ff;
   logic [LB-1:0] out_line_ff;
   logic [CB-1:0] out_col_ff;
   logic          out_done_ff;

   assign status.needs_div = needs_div;

   // Decode one request against the current state
   always_comb begin
      logic handled;
      logic do_close;
      logic e280;
      logic [7:0] b;
      handled     = 1'b0;
      do_close    = 1'b0;
      b           = req_data_byte;
      e280        = (pfx0_ff == uwpt_pkg::LEAD_E2) && (pfx1_ff == uwpt_pkg::CONT_80);
      line_in     = line_ff;
      col_in      = col_ff;
      len_in      = len_ff;
      pfx0_in     = pfx0_ff;
      pfx1_in     = pfx1_ff;
      pcnt_in     = pcnt_ff;
      after_cr_in = after_cr_ff;
      stop_in     = stop_ff;
      active_in   = active_ff;
      step_status = uwpt_pkg::ST_CONSUMED;
      needs_div   = 1'b0;

      if (req_cmd == uwpt_pkg::CMD_START) begin
         // Open a measurement
         line_in     = req_start_line;
         col_in      = req_start_col;
         len_in      = '0;
         pfx0_in     = '0;
         pfx1_in     = '0;
         pcnt_in     = '0;
         after_cr_in = 1'b0;
         stop_in     = req_one_newline;
         active_in   = 1'b1;
         step_status = uwpt_pkg::ST_STARTED;
      end else if (!active_ff) begin
         step_status = uwpt_pkg::ST_IGNORED;
      end else begin
         // Byte following a carriage return
         if (after_cr_ff) begin
            after_cr_in = 1'b0;
            if (b == uwpt_pkg::CH_LF) begin
               len_in   = sat_len(len_ff, 2'd1);
               do_close = stop_ff;
               handled  = 1'b1;
            end else if (stop_ff) begin
               do_close    = 1'b1;
               step_status = uwpt_pkg::ST_STOPPED;
               handled     = 1'b1;
            end
         end

         if (!handled) begin
            priority if (pcnt_ff == 2'd0) begin
               priority if (b == uwpt_pkg::CH_SPACE || b == uwpt_pkg::CH_COMMA) begin
                  len_in  = sat_len(len_ff, 2'd1);
                  col_in  = sat_col(col_ff, TB'(1));
               end else if (b == uwpt_pkg::CH_TAB) begin
                  needs_div = 1'b1;
               end else if (b == uwpt_pkg::CH_LF) begin
                  len_in   = sat_len(len_ff, 2'd1);
                  line_in  = sat_line(line_ff);
                  col_in   = CB'(1);
                  do_close = stop_ff;
               end else if (b == uwpt_pkg::CH_CR) begin
                  len_in      = sat_len(len_ff, 2'd1);
                  line_in     = sat_line(line_ff);
                  col_in      = CB'(1);
                  after_cr_in = 1'b1;
               end else if (b == uwpt_pkg::LEAD_C2 || b == uwpt_pkg::LEAD_E1 ||
                            b == uwpt_pkg::LEAD_E2 || b == uwpt_pkg::LEAD_E3) begin
                  pfx0_in     = b;
                  pcnt_in     = 2'd1;
                  step_status = uwpt_pkg::ST_PENDING;
               end else begin
                  do_close    = 1'b1;
                  step_status = uwpt_pkg::ST_STOPPED;
               end
            end else if (pcnt_ff == 2'd1) begin
               priority if (pfx0_ff == uwpt_pkg::LEAD_C2 && b == uwpt_pkg::CONT_A0) begin
                  len_in  = sat_len(len_ff, 2'd2);
                  col_in  = sat_col(col_ff, TB'(1));
                  pcnt_in = 2'd0;
               end else if (pfx0_ff == uwpt_pkg::LEAD_C2 && b == uwpt_pkg::CONT_85) begin
                  len_in   = sat_len(len_ff, 2'd2);
                  line_in  = sat_line(line_ff);
                  col_in   = CB'(1);
                  pcnt_in  = 2'd0;
                  do_close = stop_ff;
               end else if ((pfx0_ff == uwpt_pkg::LEAD_E1 && b == uwpt_pkg::CONT_9A) ||
                            (pfx0_ff == uwpt_pkg::LEAD_E2 &&
                             (b == uwpt_pkg::CONT_80 || b == uwpt_pkg::CONT_81)) ||
                            (pfx0_ff == uwpt_pkg::LEAD_E3 && b == uwpt_pkg::CONT_80)) begin
                  pfx1_in     = b;
                  pcnt_in     = 2'd2;
                  step_status = uwpt_pkg::ST_PENDING;
               end else begin
                  do_close    = 1'b1;
                  step_status = uwpt_pkg::ST_STOPPED;
               end
            end else begin
               priority if ((pfx0_ff == uwpt_pkg::LEAD_E1 && pfx1_ff == uwpt_pkg::CONT_9A &&
                             b == uwpt_pkg::CONT_80) ||
                            (e280 && b >= uwpt_pkg::CONT_80 && b <= uwpt_pkg::CONT_8A) ||
                            (e280 && b == uwpt_pkg::CONT_AF) ||
                            (pfx0_ff == uwpt_pkg::LEAD_E2 && pfx1_ff == uwpt_pkg::CONT_81 &&
                             b == uwpt_pkg::CONT_9F) ||
                            (pfx0_ff == uwpt_pkg::LEAD_E3 && pfx1_ff == uwpt_pkg::CONT_80 &&
                             b == uwpt_pkg::CONT_80)) begin
                  len_in  = sat_len(len_ff, 2'd3);
                  col_in  = sat_col(col_ff, TB'(1));
                  pcnt_in = 2'd0;
               end else if (e280 && (b == uwpt_pkg::CONT_A8 || b == uwpt_pkg::CONT_A9)) begin
                  len_in   = sat_len(len_ff, 2'd3);
                  line_in  = sat_line(line_ff);
                  col_in   = CB'(1);
                  pcnt_in  = 2'd0;
                  do_close = stop_ff;
               end else begin
                  do_close    = 1'b1;
                  step_status = uwpt_pkg::ST_STOPPED;
               end
            end
         end

         // Close the measurement
         if (do_close) begin
            active_in   = 1'b0;
            pcnt_in     = 2'd0;
            after_cr_in = 1'b0;
         end
      end
   end

   // One restoring remainder iteration
   always_comb begin
      trial = {rem_ff, dvd_ff[CB-1]};
      if (trial >= {1'b0, ts_ff}) begin
         trial = trial - {1'b0, ts_ff};
      end
      rem_next = trial[TB-1:0];
   end

   // Tab completion: advance to the next stop
   assign tab_off = (col_ff == '0) ? '0 : rem_ff;
   assign tab_inc = ts_ff - tab_off;
   assign col_tab = sat_col(col_ff, tab_inc);
   assign len_tab = sat_len(len_ff, 2'd1);

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         tab_size_ff <= uwpt_pkg::TAB_SIZE_RESET;
      end else if (csr_write_enable) begin
         tab_size_ff <= csr_write_data;
      end
   end

   // Update the position state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff     <= LB'(1);
         col_ff      <= CB'(1);
         len_ff      <= '0;
         pfx0_ff     <= '0;
         pfx1_ff     <= '0;
         pcnt_ff     <= '0;
         after_cr_ff <= 1'b0;
         stop_ff     <= 1'b0;
         active_ff   <= 1'b0;
      end else if (cmd.accept) begin
         line_ff     <= line_in;
         col_ff      <= col_in;
         len_ff      <= len_in;
         pfx0_ff     <= pfx0_in;
         pfx1_ff     <= pfx1_in;
         pcnt_ff     <= pcnt_in;
         after_cr_ff <= after_cr_in;
         stop_ff     <= stop_in;
         active_ff   <= active_in;
      end else if (cmd.finish) begin
         col_ff <= col_tab;
         len_ff <= len_tab;
      end
   end

   // Load and iterate the remainder unit
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dvd_ff <= col_ff - CB'(1);
         rem_ff <= '0;
         ts_ff  <= (tab_size_ff == '0) ? TB'(1) : tab_size_ff;
      end else if (cmd.step) begin
         dvd_ff <= {dvd_ff[CB-2:0], 1'b0};
         rem_ff <= rem_next;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (cmd.finish) begin
            out_status_ff <= uwpt_pkg::ST_CONSUMED;
            out_len_ff    <= len_tab;
            out_line_ff   <= line_ff;
            out_col_ff    <= col_tab;
            out_done_ff   <= !active_ff;
         end else begin
            out_status_ff <= step_status;
            out_len_ff    <= len_in;
            out_line_ff   <= line_in;
            out_col_ff    <= col_in;
            out_done_ff   <= !active_in;
         end
      end
   end

   assign rsp_status     = out_status_ff;
   assign rsp_run_length = out_len_ff;
   assign rsp_line       = out_line_ff;
   assign rsp_col        = out_col_ff;
   assign rsp_done_res   = out_done_ff;

endmodule

// ===== rtl/utf8_whitespace_position_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_whitespace_position_tracker_unit
// Measures a run of ASCII and UTF-8 whitespace with line and column tracking.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one transaction per start command or text byte; a start
//   command loads line, column and the stop-after-one-newline mode. Every
//   request yields exactly one response transaction on rsp_chan with status,
//   run length, line, column and a done flag.
//   csr_write_enable/csr_write_data write the tab size; write it only while
//   no request is outstanding.
// Latency and throughput:
//   A start command or a non-tab byte is decoded in the accept cycle and its
//   response is valid in the cycle after: one request per cycle while the
//   response side takes them. A tab needs the column offset modulo the tab
//   size, computed by a restoring remainder unit at one bit per cycle over
//   the 16 column bits; no new request is accepted until the tab completes.
// Reset:
//   Line and column go to 1, run length to 0, tab size to 4, no measurement
//   is open and no response is pending.
// Stall:
//   A response holds in its output register until taken; outside a tab, a
//   new request is accepted in the same cycle the held response drains.
// ----------------------------------------------------------------------------
module utf8_whitespace_position_tracker_unit (
   input  logic                          clock,
   input  logic                          reset,
   uwpt_req_if.sink                      req_chan,
   uwpt_rsp_if.source                    rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [uwpt_pkg::TAB_BITS-1:0] csr_write_data
);

   uwpt_pkg::ctrl_cmd_type  ctrl_cmd;
   uwpt_pkg::dp_status_type dp_status;

   // Sequence handshakes and the tab remainder
   uwpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // Decode bytes and hold the position state
   uwpt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (ctrl_cmd),
      .status           (dp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_cmd          (req_chan.cmd),
      .req_data_byte    (req_chan.data_byte),
      .req_start_line   (req_chan.start_line),
      .req_start_col    (req_chan.start_col),
      .req_one_newline  (req_chan.one_newline),
      .rsp_status       (rsp_chan.status),
      .rsp_run_length   (rsp_chan.run_length),
      .rsp_line         (rsp_chan.line),
      .rsp_col          (rsp_chan.col),
      .rsp_done_res     (rsp_chan.done_res)
   );

endmodule

// ===== test/uwpt_tracker_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uwpt_tracker_checker
// Watches the request, response and tab-size ports of the whitespace tracker.
// Keeps its own copy of the tracker state, predicts one response per accepted
// request and compares every accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module uwpt_tracker_checker
   import uwpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   uwpt_req_if                 req_mon,
   uwpt_rsp_if                 rsp_mon,
   input  logic                csr_write_enable,
   input  logic [TAB_BITS-1:0] csr_write_data,
   output int                  mismatch_count,
   output int                  outstanding,
   output int                  requests_seen,
   output int                  results_checked,
   output int                  stops_seen
);

   localparam longint unsigned LINE_TOP = (64'd1 << LINE_BITS) - 1;
   localparam longint unsigned COL_TOP  = (64'd1 << COL_BITS) - 1;
   localparam longint unsigned LEN_TOP  = (64'd1 << LEN_BITS) - 1;

   typedef struct packed {
      logic [2:0]           status;
      logic [LEN_BITS-1:0]  run_length;
      logic [LINE_BITS-1:0] line;
      logic [COL_BITS-1:0]  col;
      logic                 done_res;
   } ws_position_type;

   // Tracker state as seen from outside
   logic [TAB_BITS-1:0]  tab_stop;
   logic [LINE_BITS-1:0] pos_line;
   logic [COL_BITS-1:0]  pos_col;
   logic [LEN_BITS-1:0]  ws_count;
   logic [7:0]           lead_bytes [2];
   int unsigned          lead_count;
   logic                 cr_seen;
   logic                 single_newline;
   logic                 run_open;

   ws_position_type pending_positions [$];
   ws_position_type want_pos;
   ws_position_type got_pos;

   function automatic longint unsigned sat_add(input longint unsigned v,
                                               input longint unsigned d,
                                               input longint unsigned maxv);
      return (v >= maxv || d > maxv - v) ? maxv : v + d;
   endfunction

   function automatic void close_run();
      run_open   = 1'b0;
      lead_count = 0;
      cr_seen    = 1'b0;
   endfunction

   function automatic void take_space(input int unsigned nbytes);
      ws_count   = LEN_BITS'(sat_add(ws_count, nbytes, LEN_TOP));
      pos_col    = COL_BITS'(sat_add(pos_col, 1, COL_TOP));
      lead_count = 0;
   endfunction

   function automatic void take_newline(input int unsigned nbytes);
      ws_count   = LEN_BITS'(sat_add(ws_count, nbytes, LEN_TOP));
      pos_line   = LINE_BITS'(sat_add(pos_line, 1, LINE_TOP));
      pos_col    = COL_BITS'(1);
      lead_count = 0;
      if (single_newline) close_run();
   endfunction

   // Advance the tracker by one request and queue the response it must give
   function automatic void track_request(input logic                 cmd,
                                         input logic [7:0]           b,
                                         input logic [LINE_BITS-1:0] first_line,
                                         input logic [COL_BITS-1:0]  first_col,
                                         input logic                 newline_stop);
      logic [2:0]      st;
      logic            taken;
      logic            e280;
      int unsigned     ts;
      int unsigned     off;
      ws_position_type res;

      st    = ST_CONSUMED;
      taken = 1'b0;
      if (cmd == CMD_START) begin
         pos_line       = first_line;
         pos_col        = first_col;
         ws_count       = '0;
         lead_bytes[0]  = 8'h00;
         lead_bytes[1]  = 8'h00;
         lead_count     = 0;
         cr_seen        = 1'b0;
         single_newline = newline_stop;
         run_open       = 1'b1;
         st             = ST_STARTED;
      end else if (!run_open) begin
         st = ST_IGNORED;
      end else begin
         // byte after a CR: LF completes CRLF without another line advance
         if (cr_seen) begin
            cr_seen = 1'b0;
            if (b == CH_LF) begin
               ws_count = LEN_BITS'(sat_add(ws_count, 1, LEN_TOP));
               if (single_newline) close_run();
               taken = 1'b1;
            end else if (single_newline) begin
               close_run();
               st    = ST_STOPPED;
               taken = 1'b1;
            end
         end
         if (!taken) begin
            e280 = (lead_bytes[0] == LEAD_E2) && (lead_bytes[1] == CONT_80);
            if (lead_count == 0) begin
               if (b == CH_SPACE || b == CH_COMMA) begin
                  take_space(1);
               end else if (b == CH_TAB) begin
                  // jump to the next tab stop; zero tab size acts as one
                  ts       = (tab_stop == '0) ? 1 : 32'(tab_stop);
                  off      = (pos_col == '0) ? 0 : (32'(pos_col) - 1) % ts;
                  ws_count = LEN_BITS'(sat_add(ws_count, 1, LEN_TOP));
                  pos_col  = COL_BITS'(sat_add(pos_col, ts - off, COL_TOP));
               end else if (b == CH_LF) begin
                  take_newline(1);
               end else if (b == CH_CR) begin
                  ws_count = LEN_BITS'(sat_add(ws_count, 1, LEN_TOP));
                  pos_line = LINE_BITS'(sat_add(pos_line, 1, LINE_TOP));
                  pos_col  = COL_BITS'(1);
                  cr_seen  = 1'b1;
               end else if (b == LEAD_C2 || b == LEAD_E1 || b == LEAD_E2 || b == LEAD_E3) begin
                  lead_bytes[0] = b;
                  lead_count    = 1;
                  st            = ST_PENDING;
               end else begin
                  close_run();
                  st = ST_STOPPED;
               end
            end else if (lead_count == 1) begin
               if (lead_bytes[0] == LEAD_C2 && b == CONT_A0) begin
                  take_space(2);
               end else if (lead_bytes[0] == LEAD_C2 && b == CONT_85) begin
                  take_newline(2);
               end else if ((lead_bytes[0] == LEAD_E1 && b == CONT_9A) ||
                            (lead_bytes[0] == LEAD_E2 && (b == CONT_80 || b == CONT_81)) ||
                            (lead_bytes[0] == LEAD_E3 && b == CONT_80)) begin
                  lead_bytes[1] = b;
                  lead_count    = 2;
                  st            = ST_PENDING;
               end else begin
                  close_run();
                  st = ST_STOPPED;
               end
            end else begin
               if ((lead_bytes[0] == LEAD_E1 && lead_bytes[1] == CONT_9A && b == CONT_80) ||
                   (e280 && b >= CONT_80 && b <= CONT_8A) ||
                   (e280 && b == CONT_AF) ||
                   (lead_bytes[0] == LEAD_E2 && lead_bytes[1] == CONT_81 && b == CONT_9F) ||
                   (lead_bytes[0] == LEAD_E3 && lead_bytes[1] == CONT_80 && b == CONT_80)) begin
                  take_space(3);
               end else if (e280 && (b == CONT_A8 || b == CONT_A9)) begin
                  take_newline(3);
               end else begin
                  close_run();
                  st = ST_STOPPED;
               end
            end
         end
      end

      res.status     = st;
      res.run_length = ws_count;
      res.line       = pos_line;
      res.col        = pos_col;
      res.done_res   = !run_open;
      pending_positions.push_back(res);
   endfunction

   function automatic void report_mismatch(input string           what,
                                           input ws_position_type want,
                                           input ws_position_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"[%0t] %s: status %0d/%0d run_length %0d/%0d line %0d/%0d",
                   " col %0d/%0d done %0d/%0d (expected/actual)"},
                  $time, what, want.status, got.status, want.run_length, got.run_length,
                  want.line, got.line, want.col, got.col, want.done_res, got.done_res);
   endfunction

   // Compare drained responses first, then predict the newly accepted request
   always @(posedge clock) begin
      if (reset) begin
         tab_stop       = TAB_SIZE_RESET;
         pos_line       = LINE_BITS'(1);
         pos_col        = COL_BITS'(1);
         ws_count       = '0;
         lead_bytes[0]  = 8'h00;
         lead_bytes[1]  = 8'h00;
         lead_count     = 0;
         cr_seen        = 1'b0;
         single_newline = 1'b0;
         run_open       = 1'b0;
         pending_positions.delete();
      end else begin
         if (csr_write_enable) tab_stop = csr_write_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_pos = '{status:     rsp_mon.status,
                        run_length: rsp_mon.run_length,
                        line:       rsp_mon.line,
                        col:        rsp_mon.col,
                        done_res:   rsp_mon.done_res};
            results_checked++;
            if (got_pos.status == ST_STOPPED) stops_seen++;
            if (pending_positions.size() == 0) begin
               report_mismatch("response with nothing outstanding", '0, got_pos);
            end else begin
               want_pos = pending_positions.pop_front();
               if (got_pos !== want_pos) report_mismatch("response mismatch", want_pos, got_pos);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            requests_seen++;
            track_request(req_mon.cmd, req_mon.data_byte, req_mon.start_line,
                          req_mon.start_col, req_mon.one_newline);
         end
      end
      outstanding <= pending_positions.size();
   end

endmodule

// ===== test/utf8_whitespace_position_tracker_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_whitespace_position_tracker_unit_tb
// Drives start commands and text bytes into the whitespace tracker: a short
// directed walk over whitespace forms and stop cases, then random runs of
// well-formed whitespace with random terminators and noise, under several tab
// sizes and one short run that pushes line and column to their limits.
// Checking is done by the tracker checker instantiated beside the block.
// ----------------------------------------------------------------------------
module utf8_whitespace_position_tracker_unit_tb;
   import uwpt_pkg::*;

   localparam int unsigned LINE_TOP    = (1 << LINE_BITS) - 1;
   localparam int unsigned COL_TOP     = (1 << COL_BITS) - 1;
   localparam int          PHASE_ITEMS = 220;
   localparam int          TIMEOUT_NS  = 10_000_000;

   localparam logic [7:0] CH_LETTER_A = 8'h41;
   localparam logic [7:0] CH_LETTER_X = 8'h78;

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_write_enable;
   logic [TAB_BITS-1:0] csr_write_data;
   logic                stall_free;
   int                  items_sent;
   int                  tab_settings;

   int mismatch_count;
   int outstanding;
   int requests_seen;
   int results_checked;
   int stops_seen;

   uwpt_req_if req_bus ();
   uwpt_rsp_if rsp_bus ();

   utf8_whitespace_position_tracker_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   uwpt_tracker_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding),
      .requests_seen    (requests_seen),
      .results_checked  (results_checked),
      .stops_seen       (stops_seen)
   );

   always #6 clock = ~clock;

   // Stall the response side at random unless the stall-free stretch is on
   always @(posedge clock) begin
      if (stall_free) rsp_bus.ready <= 1'b1;
      else rsp_bus.ready <= ($urandom_range(99) >= 32);
   end

   // Present one request, with random idle cycles ahead, and hold it until taken
   task automatic drive_req(input logic                 cmd,
                            input logic [7:0]           b,
                            input logic [LINE_BITS-1:0] first_line,
                            input logic [COL_BITS-1:0]  first_col,
                            input logic                 newline_stop);
      while (!stall_free && $urandom_range(99) < 32) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= cmd;
      req_bus.data_byte   <= b;
      req_bus.start_line  <= first_line;
      req_bus.start_col   <= first_col;
      req_bus.one_newline <= newline_stop;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic send_start(input logic [LINE_BITS-1:0] first_line,
                             input logic [COL_BITS-1:0]  first_col,
                             input logic                 newline_stop);
      drive_req(CMD_START, 8'($urandom), first_line, first_col, newline_stop);
      items_sent++;
   endtask

   // Unused start fields carry random values so their bits toggle too
   task automatic send_byte(input logic [7:0] b);
      drive_req(CMD_BYTE, b, LINE_BITS'($urandom), COL_BITS'($urandom), 1'($urandom));
      items_sent++;
   endtask

   // Raw bytes that mostly land on a closed measurement
   task automatic send_noise(input int count);
      repeat (count)
         drive_req(CMD_BYTE, 8'($urandom), LINE_BITS'($urandom), COL_BITS'($urandom),
                   1'($urandom));
   endtask

   // Drop valid and hold until every response has been taken
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Random measurements: a start, a run of whitespace, then a terminator
   task automatic run_random_text(input int budget);
      int                   stop_at;
      logic [LINE_BITS-1:0] first_line;
      logic [COL_BITS-1:0]  first_col;

      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 8) send_noise($urandom_range(1, 4));

         case ($urandom_range(0, 9))
            0:       first_line = LINE_BITS'(LINE_TOP - $urandom_range(0, 2));
            1:       first_line = '0;
            default: first_line = LINE_BITS'($urandom_range(1, LINE_TOP));
         endcase
         case ($urandom_range(0, 9))
            0:       first_col = COL_BITS'(COL_TOP - $urandom_range(0, 70));
            1:       first_col = '0;
            2, 3:    first_col = COL_BITS'($urandom_range(1, 24));
            default: first_col = COL_BITS'($urandom_range(1, COL_TOP));
         endcase
         send_start(first_line, first_col, $urandom_range(0, 2) == 0);

         // whitespace tokens, spaces weighted up
         repeat ($urandom_range(0, 12)) begin
            case ($urandom_range(0, 15))
               0:  send_byte(CH_COMMA);
               1:  send_byte(CH_TAB);
               2:  send_byte(CH_LF);
               3:  send_byte(CH_CR);
               4:  begin send_byte(CH_CR); send_byte(CH_LF); end
               5:  begin send_byte(LEAD_C2); send_byte(CONT_A0); end
               6:  begin send_byte(LEAD_C2); send_byte(CONT_85); end
               7:  begin send_byte(LEAD_E1); send_byte(CONT_9A); send_byte(CONT_80); end
               8:  begin
                  send_byte(LEAD_E2);
                  send_byte(CONT_80);
                  send_byte(CONT_80 + 8'($urandom_range(0, 10)));
               end
               9:  begin send_byte(LEAD_E2); send_byte(CONT_80); send_byte(CONT_AF); end
               10: begin send_byte(LEAD_E2); send_byte(CONT_81); send_byte(CONT_9F); end
               11: begin send_byte(LEAD_E3); send_byte(CONT_80); send_byte(CONT_80); end
               12: begin
                  send_byte(LEAD_E2);
                  send_byte(CONT_80);
                  send_byte($urandom_range(0, 1) ? CONT_A8 : CONT_A9);
               end
               default: send_byte(CH_SPACE);
            endcase
         end

         case ($urandom_range(0, 4))
            0, 1: send_byte(8'($urandom));
            2: begin
               // broken multibyte sequence: a partial prefix, then a random byte
               case ($urandom_range(0, 7))
                  0: send_byte(LEAD_C2);
                  1: send_byte(LEAD_E1);
                  2: send_byte(LEAD_E2);
                  3: send_byte(LEAD_E3);
                  4: begin send_byte(LEAD_E1); send_byte(CONT_9A); end
                  5: begin send_byte(LEAD_E2); send_byte(CONT_80); end
                  6: begin send_byte(LEAD_E2); send_byte(CONT_81); end
                  default: begin send_byte(LEAD_E3); send_byte(CONT_80); end
               endcase
               send_byte(8'($urandom));
            end
            3: ;  // left open, the next start cuts in
            default: begin
               send_byte(8'($urandom));
               send_noise($urandom_range(1, 3));
            end
         endcase
      end
   endtask

   initial begin
      logic [TAB_BITS-1:0] tab_plan [5];

      reset               <= 1'b1;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.cmd         <= CMD_START;
      req_bus.data_byte   <= 8'h00;
      req_bus.start_line  <= '0;
      req_bus.start_col   <= '0;
      req_bus.one_newline <= 1'b0;
      stall_free   = 1'b0;
      items_sent   = 0;
      tab_settings = 1;
      tab_plan = '{TAB_BITS'(1), TAB_BITS'(64), TAB_BITS'(0), TAB_BITS'(127),
                   TAB_BITS'($urandom_range(2, 63))};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed walk at the reset tab size
      send_byte(CH_SPACE);                 // no measurement open yet
      send_start('0, '0, 1'b0);            // zero line and column taken as given
      send_byte(CH_TAB);                   // tab from column zero
      send_byte(CH_SPACE);
      send_byte(CH_COMMA);
      send_byte(LEAD_C2);
      send_byte(CONT_A0);
      send_byte(LEAD_E2);
      send_byte(CONT_80);
      send_byte(CONT_8A);
      send_byte(LEAD_E2);
      send_byte(CONT_80);
      send_byte(CONT_A9);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(LEAD_E3);
      send_byte(CONT_80);
      send_byte(CH_LETTER_A);              // failed prefix ends the run
      send_start(LINE_BITS'(LINE_TOP), COL_BITS'(COL_TOP), 1'b1);
      send_byte(LEAD_C2);
      send_byte(CONT_85);                  // NEL at the line limit, one-newline stop
      send_start(LINE_BITS'(1), COL_BITS'(1), 1'b1);
      send_byte(CH_CR);
      send_byte(CH_LETTER_X);              // non-LF after CR in one-newline mode

      run_random_text(PHASE_ITEMS / 2);

      // One phase per tab size; the first one runs without idling
      foreach (tab_plan[i]) begin
         drain_responses();
         csr_write_enable <= 1'b1;
         csr_write_data   <= tab_plan[i];
         @(posedge clock);
         csr_write_enable <= 1'b0;
         tab_settings++;
         stall_free = (i == 0);
         run_random_text(PHASE_ITEMS);
         if (i == 0) begin
            // one short run to pin line and column at their limits
            send_start(LINE_BITS'(LINE_TOP - 1), COL_BITS'(COL_TOP - 2), 1'b0);
            repeat (4) send_byte(CH_SPACE);
            send_byte(CH_TAB);
            repeat (3) send_byte(CH_LF);
            send_byte(CH_LETTER_X);
            stall_free = 1'b0;
         end
      end

      drain_responses();
      repeat (20) @(posedge clock);
      $display("Drove %0d transactions over %0d tab sizes, with line and column limits hit.",
               requests_seen, tab_settings);
      $display("Checked %0d responses, %0d of them stops at non-whitespace; %0d mismatches.",
               results_checked, stops_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("utf8_whitespace_position_tracker_unit_tb OK");
      end else begin
         $display("utf8_whitespace_position_tracker_unit_tb NOT OK");
      end
      $finish;
   end

   // Watchdog for a hung handshake
   initial begin
      #(TIMEOUT_NS);
      $display("utf8_whitespace_position_tracker_unit_tb NOT OK");
      $finish;
   end

endmodule

// ===== utf8_whitespace_position_tracker_unit.f =====
+incdir+rtl
rtl/uwpt_pkg.sv
rtl/uwpt_req_if.sv
rtl/uwpt_rsp_if.sv
rtl/uwpt_ctrl.sv
rtl/uwpt_datapath.sv
rtl/utf8_whitespace_position_tracker_unit.sv
test/uwpt_tracker_checker.sv
test/utf8_whitespace_position_tracker_unit_tb.sv
